/* rtl/dcdm_pkg.sv */
// ----------------------------------------------------------------------------
// dcdm_pkg
// types, register map and seven-segment table for the debounced counter
// display multiplexer
// ----------------------------------------------------------------------------
package dcdm_pkg;

  localparam int unsigned PeriodWidth = 5;
  localparam int unsigned DataWidth   = 8;
  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned BusWidth    = 32;

  localparam logic [PeriodWidth-1:0] PeriodReset = 5'd20;

  // register word index taken from paddr[2]
  localparam logic RegDebouncePeriod = 1'b0;

  // digit select code for the phase that is never reached
  localparam logic [1:0] DselNone = 2'd3;

  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

  typedef struct packed {
    logic                 up_level;
    logic                 down_level;
    logic                 sample_valid;
    logic [DataWidth-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] segment_drive;
    logic [1:0]           digit_select;
    logic                 alarm;
    logic [DataWidth-1:0] count_value;
  } out_item_t;

  // bit 0 = segment a ... bit 6 = segment g
  function automatic logic [DataWidth-1:0] seg_decode(input logic [3:0] nibble);
    logic [DataWidth-1:0] pattern;
    begin
      unique case (nibble)
        4'h0: pattern = 8'h3F;
        4'h1: pattern = 8'h06;
        4'h2: pattern = 8'h5B;
        4'h3: pattern = 8'h4F;
        4'h4: pattern = 8'h66;
        4'h5: pattern = 8'h6D;
        4'h6: pattern = 8'h7D;
        4'h7: pattern = 8'h07;
        4'h8: pattern = 8'h7F;
        4'h9: pattern = 8'h6F;
        4'hA: pattern = 8'h77;
        4'hB: pattern = 8'h7C;
        4'hC: pattern = 8'h39;
        4'hD: pattern = 8'h5E;
        4'hE: pattern = 8'h79;
        default: pattern = 8'h71;
      endcase
      return pattern;
    end
  endfunction

endpackage

/* rtl/debounced_counter_display_mux_top.sv */
// output: a tick's result is registered, into the result register or into the skid entry while the consumer holds off
// throughput: one tick per cycle; a two-entry output stage (result + skid)
// keeps accepting while the consumer holds off, and stalls only when both full
// reset: synchronous, active high; counter, held sample, locks, phase and
// debounce timer clear, period register returns to 20, no tick taken in reset
// ----------------------------------------------------------------------------
// debounced_counter_display_mux_top
// debounced up/down counter with a three-phase seven-segment multiplexer
// ----------------------------------------------------------------------------
module debounced_counter_display_mux_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dcdm_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dcdm_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dcdm_pkg::AddrWidth-1:0]    paddr,
  input  logic [dcdm_pkg::BusWidth-1:0]     pwdata,
  output logic [dcdm_pkg::BusWidth-1:0]     prdata,
  output logic                              pready
);
  import dcdm_pkg::*;

  logic [PeriodWidth-1:0] debounce_period;
  logic [DataWidth-1:0]   count_reg;
  logic [DataWidth-1:0]   sample_hold;
  logic                   up_lock_reg;
  logic                   down_lock_reg;
  phase_t                 mux_phase;
  logic [PeriodWidth-1:0] debounce_ticks;

  logic [DataWidth-1:0]   count_next;
  logic [DataWidth-1:0]   count_up;
  logic [DataWidth-1:0]   hold_next;
  logic                   up_lock_next;
  logic                   down_lock_next;
  phase_t                 phase_next;
  logic [PeriodWidth-1:0] ticks_next;
  logic [PeriodWidth-1:0] ticks_inc;
  logic                   fire;
  logic                   up_hit;
  logic                   down_hit;
  out_item_t              result;

  out_item_t              skid_data;
  logic                   skid_valid;
  logic                   accept;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !skid_valid && !rst;
  assign accept    = in_valid && in_ready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegDebouncePeriod) begin
      prdata = {{(BusWidth-PeriodWidth){1'b0}}, debounce_period};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_period <= PeriodReset;
    end else if (cfg_write && paddr[2] == RegDebouncePeriod) begin
      debounce_period <= pwdata[PeriodWidth-1:0];
    end
  end

  // tick datapath
  always_comb begin
    hold_next = in_data.sample_valid ? in_data.sample_value : sample_hold;

    result = '0;
    unique case (mux_phase)
      PH_HIGH: begin
        result.segment_drive = seg_decode(hold_next[7:4]);
        result.digit_select  = PH_HIGH;
        phase_next           = PH_LOW;
      end
      PH_LOW: begin
        result.segment_drive = seg_decode(hold_next[3:0]);
        result.digit_select  = PH_LOW;
        phase_next           = PH_COUNT;
      end
      PH_COUNT: begin
        result.segment_drive = count_reg;
        result.digit_select  = PH_COUNT;
        phase_next           = PH_HIGH;
      end
      default: begin
        result.segment_drive = '0;
        result.digit_select  = DselNone;
        phase_next           = PH_HIGH;
      end
    endcase

    ticks_inc  = debounce_ticks + 1'b1;
    fire       = (ticks_inc >= debounce_period);
    ticks_next = fire ? '0 : ticks_inc;
    up_hit     = fire && !in_data.up_level;
    down_hit   = fire && !in_data.down_level;

    // up step first, then down
    count_up     = (up_hit && !up_lock_reg) ? count_reg + 1'b1 : count_reg;
    up_lock_next = up_hit ? 1'b1 : (in_data.up_level ? 1'b0 : up_lock_reg);

    count_next     = (down_hit && !down_lock_reg) ? count_up - 1'b1 : count_up;
    down_lock_next = down_hit ? 1'b1 : (in_data.down_level ? 1'b0 : down_lock_reg);

    result.alarm       = (hold_next > count_next);
    result.count_value = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg      <= '0;
      sample_hold    <= '0;
      up_lock_reg    <= 1'b0;
      down_lock_reg  <= 1'b0;
      mux_phase      <= PH_HIGH;
      debounce_ticks <= '0;
    end else if (accept) begin
      count_reg      <= count_next;
      sample_hold    <= hold_next;
      up_lock_reg    <= up_lock_next;
      down_lock_reg  <= down_lock_next;
      mux_phase      <= phase_next;
      debounce_ticks <= ticks_next;
    end
  end

  // result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in front");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no result");

  a_count_direct: assert property (@(posedge clk) disable iff (rst)
    (accept && (out_ready || !out_valid)) |=> out_data.count_value == count_reg)
    else $error("shown count differs from counter");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count_reg))
    else $error("counter moved without a tick");
`endif

endmodule
